// ===== rtl/ritx_pkg.sv =====
`timescale 1ns / 1ps
package ritx_pkg;

  localparam int RowAw = 7;
  localparam int ColAw = 11;

  typedef enum logic [1:0] {
    OP_PIXEL    = 2'd0,
    OP_LOAD_ROW = 2'd1,
    OP_LOAD_COL = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S8  = 3'd1,
    FMT_U16 = 3'd2,
    FMT_S16 = 3'd3,
    FMT_U32 = 3'd4,
    FMT_S32 = 3'd5,
    FMT_F32 = 3'd6,
    FMT_F64 = 3'd7
  } fmt_t;

  typedef enum logic [2:0] {
    REG_MULT   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_FORMAT = 3'd2,
    REG_SWAP   = 3'd3,
    REG_WIDTH  = 3'd4
  } reg_idx_t;

  // Configuration bundle handed from top to datapath.
  typedef struct packed {
    logic signed [31:0] mult;
    logic signed [31:0] offset;
    logic [2:0]         fmt;
    logic               swap;
    logic [11:0]        width;
  } cfg_t;

  // Table read-back, one per pixel.
  typedef struct packed {
    logic signed [15:0] sb;
    logic signed [15:0] cb;
    logic signed [15:0] se;
    logic signed [15:0] ce;
    logic signed [15:0] sa;
    logic signed [15:0] ca;
  } trig_t;

  // Round to nearest, ties up: add half then arithmetic shift (floor).
  function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] w;
    w = v + 48'sd8192;
    return w >>> 14;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/ritx_tables.sv =====
`timescale 1ns / 1ps
module ritx_tables (
  input  logic                     clk,
  input  logic                     row_we,
  input  logic [ritx_pkg::RowAw-1:0] row_waddr,
  input  logic [63:0]              row_wdata,
  input  logic                     col_we,
  input  logic [ritx_pkg::ColAw-1:0] col_waddr,
  input  logic [31:0]              col_wdata,
  input  logic                     rd_en,
  input  logic [ritx_pkg::RowAw-1:0] row_raddr,
  input  logic [ritx_pkg::ColAw-1:0] col_raddr,
  output ritx_pkg::trig_t          trig
);
  import ritx_pkg::*;

  logic [63:0] row_mem [2**RowAw];
  logic [31:0] col_mem [2**ColAw];
  logic [63:0] row_q;
  logic [31:0] col_q;

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (rd_en) row_q <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_waddr] <= col_wdata;
    if (rd_en) col_q <= col_mem[col_raddr];
  end

  // Loads and pixels are ordered in the stream; a read one item behind a
  // write to the same entry sees the new data because the write lands first.
  assign trig = {row_q, col_q};
endmodule

// ===== rtl/ritx_decode.sv =====
`timescale 1ns / 1ps
module ritx_decode (
  input  logic [63:0]        raw,
  input  logic [2:0]         fmt,
  input  logic               swap,
  output logic               finite,
  output logic               neg,
  output logic [51:0]        mag
);
  import ritx_pkg::*;

  logic [63:0] v;
  logic [52:0] m;
  logic signed [12:0] sh;
  logic [10:0] e;
  logic [64+48:0] wide;

  always_comb begin
    v = '0;
    case (fmt)
      FMT_U8, FMT_S8: v = {56'd0, raw[7:0]};
      FMT_U16, FMT_S16: v = swap ? {48'd0, raw[7:0], raw[15:8]} : {48'd0, raw[15:0]};
      FMT_U32, FMT_S32, FMT_F32:
        v = swap ? {32'd0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]}
                 : {32'd0, raw[31:0]};
      default:
        v = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24],
                    raw[39:32], raw[47:40], raw[55:48], raw[63:56]} : raw;
    endcase
    finite = 1'b1;
    neg = 1'b0;
    mag = '0;
    m = '0;
    e = '0;
    sh = '0;
    wide = '0;
    case (fmt)
      FMT_F32, FMT_F64: begin
        if (fmt == FMT_F32) begin
          e = {3'd0, v[30:23]};
          m = {30'd0, v[22:0]};
          finite = (v[30:23] != 8'hff);
          neg = v[31];
          if (e == 11'd0) e = 11'd1; else m[23] = 1'b1;
          sh = $signed({2'b00, e}) - 13'sd134;
        end else begin
          e = v[62:52];
          m = {1'b0, v[51:0]};
          finite = (v[62:52] != 11'h7ff);
          neg = v[63];
          if (e == 11'd0) e = 11'd1; else m[52] = 1'b1;
          sh = $signed({2'b00, e}) - 13'sd1059;
        end
        // left shifts saturate at 2^48; right shifts of a double keep up to 52 bits
        if (m == '0) mag = '0;
        else if (sh >= 0) begin
          if (sh > 13'sd48) mag = 52'h1_0000_0000_0000;
          else begin
            wide = {60'd0, m} << sh[5:0];
            if (wide > 113'h1_0000_0000_0000) mag = 52'h1_0000_0000_0000;
            else mag = wide[51:0];
          end
        end else if (sh <= -13'sd64) mag = '0;
        else begin
          wide = {60'd0, m} >> (7'(-sh));
          mag = wide[51:0];
        end
      end
      default: begin
        if (fmt[0]) begin
          case (fmt)
            FMT_S8:  neg = v[7];
            FMT_S16: neg = v[15];
            default: neg = v[31];
          endcase
        end
        if (neg) begin
          case (fmt)
            FMT_S8:  v = 64'h100 - v;
            FMT_S16: v = 64'h1_0000 - v;
            default: v = 64'h1_0000_0000 - v;
          endcase
        end
        mag = {3'd0, v[32:0], 16'd0};
      end
    endcase
  end
endmodule

// ===== rtl/ritx_datapath.sv =====
`timescale 1ns / 1ps
module ritx_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [6:0]      row,
  input  logic [10:0]     column,
  input  logic [63:0]     raw,
  input  ritx_pkg::cfg_t  cfg,
  input  ritx_pkg::trig_t trig,
  output logic            out_valid,
  output logic [17:0]     point_index,
  output logic            point_valid,
  output logic [31:0]     x_m,
  output logic [31:0]     y_m,
  output logic [31:0]     z_m
);
  import ritx_pkg::*;

  // s1: decode; table read issued in parallel
  logic s1_v, s1_fin, s1_neg; logic [51:0] s1_mag; logic [17:0] s1_idx;
  logic d_fin, d_neg; logic [51:0] d_mag;
  ritx_decode u_dec (.raw(raw), .fmt(cfg.fmt), .swap(cfg.swap),
                     .finite(d_fin), .neg(d_neg), .mag(d_mag));

  // s2: range scaling products (36x32 and 16x32 pieces, sum wraps at 64 bits)
  logic s2_v, s2_fin, s2_sgn; logic [17:0] s2_idx;
  logic [63:0] s2_hi; logic [47:0] s2_lo; trig_t s2_trig;
  logic [31:0] mm;
  assign mm = cfg.mult[31] ? 32'(-cfg.mult) : cfg.mult;

  // s3: range + angle sum products
  logic s3_v, s3_ok; logic [17:0] s3_idx; logic signed [31:0] s3_rng;
  logic signed [31:0] p_cc, p_ss, p_sc, p_cs; trig_t s3_trig;
  logic [63:0] prod; logic signed [47:0] sv, rng_w;
  // s4: rotation step one
  logic s4_v, s4_ok; logic [17:0] s4_idx; logic signed [47:0] s4_t, s4_z;
  logic signed [47:0] s4_caz, s4_saz;
  logic signed [47:0] caz, saz, t_w, z_w;
  // output stage: t fits 34 bits, the angle sums 19 bits
  logic signed [63:0] xp, yp;
  logic signed [47:0] xr, yr;

  assign prod = s2_hi + {32'd0, s2_lo[47:16]};

  always_comb begin
    sv = (prod > 64'h100_0000_0000) ? 48'sh100_0000_0000 : $signed(prod[47:0]);
    if (s2_sgn) sv = -sv;
    rng_w = 48'(sat32(sv + 48'(cfg.offset)));
    caz = rnd14(48'(p_cc) - 48'(p_ss));
    saz = rnd14(48'(p_sc) + 48'(p_cs));
    t_w = rnd14(48'(s3_rng * s3_trig.ce));
    z_w = rnd14(48'(s3_rng * s3_trig.se));
    xp = 64'($signed(s4_t[33:0]) * $signed(s4_caz[18:0]));
    yp = 64'($signed(s4_t[33:0]) * $signed(s4_saz[18:0]));
    xr = 48'((xp + 64'sd8192) >>> 14);
    yr = 48'((yp + 64'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid; s2_v <= s1_v; s3_v <= s2_v; s4_v <= s3_v; out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fin <= d_fin; s1_neg <= d_neg; s1_mag <= d_mag;
      s1_idx <= 18'(row * cfg.width + {7'd0, column});

      s2_fin <= s1_fin; s2_idx <= s1_idx; s2_trig <= trig;
      s2_sgn <= s1_neg ^ cfg.mult[31];
      s2_hi <= 64'(s1_mag[51:16] * mm);
      s2_lo <= {32'd0, s1_mag[15:0]} * mm;

      s3_idx <= s2_idx; s3_trig <= s2_trig;
      s3_rng <= rng_w[31:0];
      s3_ok <= s2_fin && (rng_w > 48'sd0);
      p_cc <= s2_trig.ca * s2_trig.cb; p_ss <= s2_trig.sa * s2_trig.sb;
      p_sc <= s2_trig.sa * s2_trig.cb; p_cs <= s2_trig.ca * s2_trig.sb;

      s4_idx <= s3_idx; s4_ok <= s3_ok;
      s4_t <= t_w; s4_z <= z_w; s4_caz <= caz; s4_saz <= saz;

      point_index <= s4_idx; point_valid <= s4_ok;
      x_m <= s4_ok ? sat32(xr) : '0;
      y_m <= s4_ok ? sat32(yr) : '0;
      z_m <= s4_ok ? sat32(s4_z) : '0;
    end
  end
endmodule

// ===== rtl/range_image_to_xyz_projection.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields (tdata low bit up)
// s_axis   in   op[1:0] row[8:2] column[19:9] raw[83:20] cos_a sin_a cos_b sin_b (pad to 152)
// m_axis   out  point_index[17:0] point_valid[18] x_m[50:19] y_m[82:51] z_m[114:83]
// cfg      in   cfg_we, cfg_index, cfg_data (32)
// One request per cycle while the output is not stalled; pixels pass through
// the table read, scale, angle-sum and rotate stages. Loads write the memories
// directly and make no result. Reset clears pipeline valids and registers;
// the tables hold whatever was loaded. A stalled output freezes the pipe.
module range_image_to_xyz_projection (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [151:0]  s_axis_tdata,  // operation,row,column,raw_sample,cos_a,sin_a,cos_b,sin_b
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata,  // point_index,point_valid,x_m,y_m,z_m
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import ritx_pkg::*;

  cfg_t cfg;
  trig_t trig;
  logic en, acc, pix;
  logic [1:0] op;
  logic [17:0] pidx; logic pval; logic [31:0] px, py, pz;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc = s_axis_tvalid && en;
  assign op = s_axis_tdata[1:0];
  assign pix = acc && (op == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mult: 32'sd65536, offset: '0, fmt: FMT_S16, swap: 1'b0, width: 12'd1024};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT:   cfg.mult <= cfg_data;
        REG_OFFSET: cfg.offset <= cfg_data;
        REG_FORMAT: cfg.fmt <= cfg_data[2:0];
        REG_SWAP:   cfg.swap <= cfg_data[0];
        REG_WIDTH:  cfg.width <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ritx_tables u_tab (
    .clk(clk),
    .row_we(acc && op == OP_LOAD_ROW), .row_waddr(s_axis_tdata[8:2]),
    .row_wdata(s_axis_tdata[147:84]),
    .col_we(acc && op == OP_LOAD_COL), .col_waddr(s_axis_tdata[19:9]),
    .col_wdata(s_axis_tdata[115:84]),
    .rd_en(en), .row_raddr(s_axis_tdata[8:2]), .col_raddr(s_axis_tdata[19:9]),
    .trig(trig)
  );

  ritx_datapath u_dp (
    .clk(clk), .rst(rst), .en(en), .in_valid(pix),
    .row(s_axis_tdata[8:2]), .column(s_axis_tdata[19:9]), .raw(s_axis_tdata[83:20]),
    .cfg(cfg), .trig(trig), .out_valid(m_axis_tvalid),
    .point_index(pidx), .point_valid(pval), .x_m(px), .y_m(py), .z_m(pz)
  );

  assign m_axis_tdata = {5'd0, pz, py, px, pval, pidx};
endmodule

// ===== rtl/ritx_checker.sv =====
`timescale 1ns / 1ps
module ritx_checker (
  input logic clk, rst,
  input logic s_axis_tvalid, s_axis_tready,
  input logic m_axis_tvalid, m_axis_tready,
  input logic [119:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
  a_inv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[18] |-> m_axis_tdata[114:19] == '0)
    else $error("invalid point not zero");
endmodule

bind range_image_to_xyz_projection ritx_checker u_chk (.*);

// ===== sim/xyz_point_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, point and register channels and predicts every point.
module xyz_point_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [151:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           n_errors,
  output int           n_pending
);
  import ritx_pkg::*;

  localparam logic [63:0] MagCap  = 64'd1 << 48;
  localparam logic [63:0] ProdCap = 64'd1 << 40;

  logic signed [31:0] c_mult, c_offset;
  fmt_t               c_fmt;
  logic               c_swap;
  logic [11:0]        c_width;

  logic signed [15:0] row_ce[128], row_se[128], row_cb[128], row_sb[128];
  logic signed [15:0] col_ca[2048], col_sa[2048];

  logic [119:0] expected_points[$];

  function automatic longint round_q14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q.16 magnitude from a float mantissa, saturating at 2^48.
  function automatic logic [63:0] shift_mag(logic [63:0] m, int sh);
    if (m == 0) return 0;
    if (sh >= 0) begin
      if (sh > 48) return MagCap;
      if (m > (MagCap >> sh)) return MagCap;
      return m << sh;
    end
    if (-sh >= 64) return 0;
    return m >> (-sh);
  endfunction

  function automatic logic [119:0] project_pixel(logic [151:0] d);
    logic [6:0]  row;
    logic [10:0] col;
    logic [63:0] v, r, mag, mm, prod;
    logic [17:0] pidx;
    int          nb, e;
    logic        neg, ok;
    longint      sv, rng, ce, se, cb, sb, ca, sa, caz, saz, t, x, y, z;
    row = d[8:2];
    col = d[19:9];
    v   = d[83:20];
    case (c_fmt)
      FMT_U8, FMT_S8:            nb = 1;
      FMT_U16, FMT_S16:          nb = 2;
      FMT_U32, FMT_S32, FMT_F32: nb = 4;
      default:                   nb = 8;
    endcase
    if (nb < 8) v &= (64'd1 << (8 * nb)) - 1;
    if (c_swap && nb > 1) begin
      r = 0;
      for (int i = 0; i < nb; i++) r = (r << 8) | v[8*i +: 8];
      v = r;
    end
    neg = 0;
    ok  = 1;
    mag = 0;
    if (c_fmt == FMT_F32) begin
      e   = int'(v[30:23]);
      mag = {41'd0, v[22:0]};
      if (e == 255) ok = 0;
      else begin
        if (e == 0) e = 1;
        else mag[23] = 1'b1;
        neg = v[31];
        mag = shift_mag(mag, e - 134);
      end
    end else if (c_fmt == FMT_F64) begin
      e   = int'(v[62:52]);
      mag = {12'd0, v[51:0]};
      if (e == 2047) ok = 0;
      else begin
        if (e == 0) e = 1;
        else mag[52] = 1'b1;
        neg = v[63];
        mag = shift_mag(mag, e - 1059);
      end
    end else begin
      if (c_fmt[0] && v[8*nb-1]) begin
        neg = 1;
        v   = (64'd1 << (8 * nb)) - v;
      end
      mag = v << 16;
    end
    x = 0;
    y = 0;
    z = 0;
    if (ok) begin
      mm   = (c_mult < 0) ? 64'(-longint'(c_mult)) : 64'(longint'(c_mult));
      prod = (mag >> 16) * mm + (((mag & 64'hFFFF) * mm) >> 16);
      if (prod > ProdCap) prod = ProdCap;
      sv  = (neg != (c_mult < 0)) ? -longint'(prod) : longint'(prod);
      rng = clip32(sv + longint'(c_offset));
      ok  = rng > 0;
    end
    if (ok) begin
      ce  = row_ce[row];
      se  = row_se[row];
      cb  = row_cb[row];
      sb  = row_sb[row];
      ca  = col_ca[col];
      sa  = col_sa[col];
      caz = round_q14(ca * cb - sa * sb);
      saz = round_q14(sa * cb + ca * sb);
      t   = round_q14(rng * ce);
      x   = clip32(round_q14(t * caz));
      y   = clip32(round_q14(t * saz));
      z   = clip32(round_q14(rng * se));
    end
    pidx = 18'(int'(row) * int'(c_width) + int'(col));
    return {z[31:0], y[31:0], x[31:0], ok, pidx};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    logic [119:0] want;
    if (rst) begin
      c_mult   = 32'sd65536;
      c_offset = 0;
      c_fmt    = FMT_S16;
      c_swap   = 0;
      c_width  = 12'd1024;
      expected_points.delete();
      n_errors = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MULT:   c_mult   = cfg_data;
          REG_OFFSET: c_offset = cfg_data;
          REG_FORMAT: c_fmt    = fmt_t'(cfg_data[2:0]);
          REG_SWAP:   c_swap   = cfg_data[0];
          REG_WIDTH:  c_width  = cfg_data[11:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          $error("point with no request waiting: %0h", m_axis_tdata);
          n_errors++;
        end else begin
          want = expected_points.pop_front();
          check_field("point_index", 32'(want[17:0]), 32'(m_axis_tdata[17:0]));
          check_field("point_valid", 32'(want[18]), 32'(m_axis_tdata[18]));
          check_field("x_m", want[50:19], m_axis_tdata[50:19]);
          check_field("y_m", want[82:51], m_axis_tdata[82:51]);
          check_field("z_m", want[114:83], m_axis_tdata[114:83]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (op_t'(s_axis_tdata[1:0]))
          OP_LOAD_ROW: begin
            row_ce[s_axis_tdata[8:2]] = s_axis_tdata[99:84];
            row_se[s_axis_tdata[8:2]] = s_axis_tdata[115:100];
            row_cb[s_axis_tdata[8:2]] = s_axis_tdata[131:116];
            row_sb[s_axis_tdata[8:2]] = s_axis_tdata[147:132];
          end
          OP_LOAD_COL: begin
            col_ca[s_axis_tdata[19:9]] = s_axis_tdata[99:84];
            col_sa[s_axis_tdata[19:9]] = s_axis_tdata[115:100];
          end
          OP_PIXEL: expected_points.push_back(project_pixel(s_axis_tdata));
          default: ;
        endcase
      end
    end
    n_pending = expected_points.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top: drives requests and register writes, lets the checker judge the points.
module testbench;
  import ritx_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata;   // op, row, column, raw_sample, cos_a, sin_a, cos_b, sin_b
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [119:0] m_axis_tdata;   // point_index, point_valid, x_m, y_m, z_m
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  int n_errors, n_pending;
  int gap_pct, stall_pct;     // sender gap / receiver stall odds in percent
  bit hold_go, hold_done;     // one long receiver hold-off
  int idle_cycles;
  bit col_loaded[2048];
  int col_list[$];

  range_image_to_xyz_projection dut (.*);

  xyz_point_checker chk (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we, .cfg_index, .cfg_data, .n_errors, .n_pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [151:0] pack_request(op_t op, logic [6:0] row, logic [10:0] col,
                                                logic [63:0] raw, logic [15:0] ca,
                                                logic [15:0] sa, logic [15:0] cb,
                                                logic [15:0] sb);
    return {4'd0, sb, cb, sa, ca, raw, col, row, op};
  endfunction

  function automatic int sample_bytes(fmt_t f);
    case (f)
      FMT_U8, FMT_S8:            return 1;
      FMT_U16, FMT_S16:          return 2;
      FMT_U32, FMT_S32, FMT_F32: return 4;
      default:                   return 8;
    endcase
  endfunction

  // Put a sample in big-endian order when the block is told to swap.
  function automatic logic [63:0] order_bytes(logic [63:0] v, int nb, bit swap);
    logic [63:0] r;
    if (!swap || nb == 1) return v;
    r = 0;
    for (int i = 0; i < nb; i++) r = (r << 8) | v[8*i +: 8];
    return r;
  endfunction

  // Trig entry: rails often, unit-circle-ish values mostly, any code sometimes.
  function automatic logic [15:0] pick_trig();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [63:0] pick_raw(fmt_t f, bit swap);
    logic [63:0] v;
    int          nb;
    nb = sample_bytes(f);
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 300));
      default: begin
        v = {$urandom, $urandom};
        if (f == FMT_F32) begin
          v = (v & 64'h807FFFFF) | (64'($urandom_range(110, 165)) << 23);
          if ($urandom_range(0, 9) == 0) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (f == FMT_F64) begin
          v = (v & 64'h800FFFFFFFFFFFFF) | (64'($urandom_range(1000, 1070)) << 52);
          if ($urandom_range(0, 9) == 0) v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h0;
        end
      end
    endcase
    if (nb < 8) v &= (64'd1 << (8 * nb)) - 1;
    v = order_bytes(v, nb, swap);
    // junk above the sample must be ignored
    if (nb < 8 && $urandom_range(0, 1)) v |= {$urandom, $urandom} << (8 * nb);
    return v;
  endfunction

  // One request; may idle first, holds tvalid until accepted.
  task automatic offer(logic [151:0] d);
    int k;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 0;
      k = $urandom_range(1, 4);
      repeat (k) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_pixel(int row, int col, logic [63:0] raw);
    offer(pack_request(OP_PIXEL, row, col, raw, $urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic load_row(int row, logic [15:0] ce, logic [15:0] se, logic [15:0] cb,
                          logic [15:0] sb);
    offer(pack_request(OP_LOAD_ROW, row, $urandom, {$urandom, $urandom}, ce, se, cb, sb));
  endtask

  task automatic load_col(int col, logic [15:0] ca, logic [15:0] sa);
    offer(pack_request(OP_LOAD_COL, $urandom, col, {$urandom, $urandom}, ca, sa,
                       $urandom, $urandom));
    if (!col_loaded[col]) begin
      col_loaded[col] = 1;
      col_list.push_back(col);
    end
  endtask

  function automatic int pick_col();
    return col_list[$urandom_range(0, col_list.size() - 1)];
  endfunction

  // Registers change only with the pipe empty and settled.
  task automatic set_config(logic [31:0] mult, logic [31:0] offset, fmt_t f, bit swap,
                            logic [11:0] width);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= REG_MULT;   cfg_data <= mult;          @(posedge clk);
    cfg_index <= REG_OFFSET; cfg_data <= offset;        @(posedge clk);
    cfg_index <= REG_FORMAT; cfg_data <= 32'(f);        @(posedge clk);
    cfg_index <= REG_SWAP;   cfg_data <= 32'(swap);     @(posedge clk);
    cfg_index <= REG_WIDTH;  cfg_data <= 32'(width);    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: too long with nothing accepted anywhere.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] specials[$];
    logic [31:0] mult, offset;
    logic [11:0] width;
    fmt_t        f;
    bit          swap;
    int          nb, dice;

    rst           = 1;
    s_axis_tvalid = 0;
    s_axis_tdata  = 0;
    cfg_we        = 0;
    cfg_index     = REG_MULT;
    cfg_data      = 0;
    gap_pct       = 14;
    stall_pct     = 61;
    hold_go       = 0;
    hold_done     = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Fill every row and a spread of columns before any pixel reads them.
    for (int r = 0; r < 128; r++) load_row(r, pick_trig(), pick_trig(), pick_trig(), pick_trig());
    load_col(0, pick_trig(), pick_trig());
    load_col(2047, pick_trig(), pick_trig());
    repeat (62) load_col($urandom_range(1, 2046), pick_trig(), pick_trig());

    // Directed, reset config: s16, unit scale, width 1024.
    send_pixel(0, 0, 64'd0);
    send_pixel(127, 2047, 64'h7FFF);
    send_pixel(5, pick_col(), 64'h8000);
    send_pixel(6, pick_col(), 64'hFFFF);
    send_pixel(7, pick_col(), 64'd1);
    send_pixel(8, pick_col(), 64'hFFFF_FFFF_FFFF_0005);
    offer(pack_request(OP_UNUSED, 3, 4, 64'd100, 1, 2, 3, 4));   // ignored code
    load_row(127, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(127, pick_col(), 64'h7FFF);
    load_col(2047, 16'h7FFF, 16'h7FFF);
    send_pixel(3, 2047, 64'h1234);
    load_row(0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pixel(0, 2047, 64'h7FFF);
    send_pixel(0, 0, 64'h4000);

    for (int p = 0; p < 19; p++) begin
      f    = fmt_t'(p % 8);
      swap = (p / 8) % 2;
      case ($urandom_range(0, 3))
        0:       mult = 32'd65536;
        1:       mult = $urandom_range(1, 1 << 22);
        2:       mult = -$urandom_range(1, 1 << 22);
        default: mult = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0:       offset = 0;
        1:       offset = $urandom_range(0, 1 << 23) - (1 << 22);
        default: offset = $urandom;
      endcase
      width = $urandom_range(1, 2048);
      // extremes of the registers
      if (p == 16) begin
        f = fmt_t'($urandom_range(0, 7)); mult = 32'h8000_0000; offset = 32'h7FFF_FFFF;
        width = 0;
      end else if (p == 17) begin
        f = fmt_t'($urandom_range(0, 7)); mult = 32'h7FFF_FFFF; offset = 32'h8000_0000;
        width = 12'hFFF;
      end else if (p == 18) begin
        f = FMT_F64; swap = 1; mult = 0; offset = 1; width = 1;
      end
      set_config(mult, offset, f, swap, width);

      if (p < 6) begin
        gap_pct = 14; stall_pct = 61;
      end else if (p < 12) begin
        gap_pct = 61; stall_pct = 14;
      end else begin
        gap_pct = 0; stall_pct = 0;
      end
      if (p == 2) hold_go = 1;

      // Edge samples of this format: 0, all ones, sign edge, NaN/inf/-0/denormal/1/max.
      nb = sample_bytes(f);
      specials.delete();
      specials.push_back(64'd0);
      specials.push_back(~64'd0);
      if (nb < 8) begin
        specials.push_back(64'd1 << (8 * nb - 1));
        specials.push_back((64'd1 << (8 * nb - 1)) - 1);
      end
      if (f == FMT_F32) begin
        specials.push_back(64'h7F80_0000);
        specials.push_back(64'h7FC0_0001);
        specials.push_back(64'h8000_0000);
        specials.push_back(64'h0000_0001);
        specials.push_back(64'h3F80_0000);
        specials.push_back(64'h7F7F_FFFF);
      end else if (f == FMT_F64) begin
        specials.push_back(64'h7FF0_0000_0000_0000);
        specials.push_back(64'hFFF8_0000_0000_0001);
        specials.push_back(64'h8000_0000_0000_0000);
        specials.push_back(64'h0000_0000_0000_0001);
        specials.push_back(64'h3FF0_0000_0000_0000);
        specials.push_back(64'h7FEF_FFFF_FFFF_FFFF);
      end
      foreach (specials[i])
        send_pixel($urandom_range(0, 127), pick_col(), order_bytes(specials[i], nb, swap));

      for (int n = 0; n < 28; n++) begin
        dice = $urandom_range(0, 99);
        if (dice < 88)
          send_pixel($urandom_range(0, 127), pick_col(), pick_raw(f, swap));
        else if (dice < 94)
          load_col($urandom_range(0, 2047), pick_trig(), pick_trig());
        else if (dice < 98)
          load_row($urandom_range(0, 127), pick_trig(), pick_trig(), pick_trig(), pick_trig());
        else
          offer(pack_request(OP_UNUSED, $urandom, $urandom, {$urandom, $urandom},
                             $urandom, $urandom, $urandom, $urandom));
      end
    end

    // Drain, then let the pipe settle.
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && n_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
